// File: rtl/drfs_pkg.sv
// shared types and constants for the display rectangle fill sequencer
`default_nettype none

package drfs_pkg;

    // field widths
    localparam int COORD_W   = 9;
    localparam int COLOR_W   = 16;
    localparam int BYTE_W    = 8;
    localparam int BOUND_W   = 16;
    localparam int PIXELS_W  = 18;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // default panel geometry
    localparam int DEFAULT_PANEL_WIDTH  = 240;
    localparam int DEFAULT_PANEL_HEIGHT = 320;

    // item opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_HORIZONTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OFFSET   = 2'd1;

    localparam logic [CFG_DATA_W-1:0] COLUMN_OFFSET_RESET = 8'd35;

    // panel command bytes
    localparam logic [BYTE_W-1:0] CMD_COLUMN_WINDOW = 8'h2A;
    localparam logic [BYTE_W-1:0] CMD_ROW_WINDOW    = 8'h2B;
    localparam logic [BYTE_W-1:0] CMD_MEMORY_WRITE  = 8'h2C;

    // clipped rectangle as window bounds
    typedef struct packed {
        logic                on_panel;
        logic [BOUND_W-1:0]  col_first;
        logic [BOUND_W-1:0]  col_final;
        logic [BOUND_W-1:0]  row_first;
        logic [BOUND_W-1:0]  row_final;
        logic [PIXELS_W-1:0] pixels;
    } window_t;

endpackage

`default_nettype wire

// File: rtl/drfs_window_calc.sv
// clips a start rectangle to the panel and derives the window bounds
`default_nettype none

module drfs_window_calc #(
    parameter int PANEL_WIDTH  = drfs_pkg::DEFAULT_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = drfs_pkg::DEFAULT_PANEL_HEIGHT
) (
    input  wire logic                                scan_horizontal,
    input  wire logic [drfs_pkg::CFG_DATA_W-1:0]     column_offset,
    input  wire logic [drfs_pkg::COORD_W-1:0]        x_origin,
    input  wire logic [drfs_pkg::COORD_W-1:0]        y_origin,
    input  wire logic [drfs_pkg::COORD_W-1:0]        rect_width,
    input  wire logic [drfs_pkg::COORD_W-1:0]        rect_height,
    output drfs_pkg::window_t                        win
);

    localparam int CW = drfs_pkg::COORD_W;
    localparam int BW = drfs_pkg::BOUND_W;
    localparam int PX = drfs_pkg::PIXELS_W;
    localparam logic [CW-1:0] PW = CW'(PANEL_WIDTH);
    localparam logic [CW-1:0] PH = CW'(PANEL_HEIGHT);

    logic [CW-1:0] span_x;
    logic [CW-1:0] span_y;
    logic [CW:0]   x_end;
    logic [CW:0]   y_end;
    logic [CW-1:0] w_clip;
    logic [CW-1:0] h_clip;

    always_comb
    begin
        // horizontal scan swaps the panel axes
        span_x = scan_horizontal ? PH : PW;
        span_y = scan_horizontal ? PW : PH;

        x_end = {1'b0, x_origin} + {1'b0, rect_width};
        y_end = {1'b0, y_origin} + {1'b0, rect_height};

        w_clip = (x_end > {1'b0, span_x}) ? (span_x - x_origin) : rect_width;
        h_clip = (y_end > {1'b0, span_y}) ? (span_y - y_origin) : rect_height;

        win.on_panel  = (x_origin < span_x) && (y_origin < span_y);
        win.col_first = BW'(x_origin) + BW'(column_offset);
        // final bound falls one below the first bound when the size is zero
        win.col_final = BW'(x_origin) + BW'(w_clip) + BW'(column_offset) - BW'(1);
        win.row_first = BW'(y_origin);
        win.row_final = BW'(y_origin) + BW'(h_clip) - BW'(1);
        win.pixels    = PX'(w_clip) * PX'(h_clip);
    end

endmodule

`default_nettype wire

// File: rtl/display_rect_fill_sequencer.sv
// top level of the display rectangle fill sequencer
`default_nettype none

//  channel | signals                                           | role
//  --------+---------------------------------------------------+------------------------------
//  req     | req_valid/req_ready, op, x_origin, y_origin,      | start transaction or byte tick
//          | rect_width, rect_height, fill_value               |
//  rsp     | rsp_valid/rsp_ready, out_byte, is_data,           | one panel byte per busy tick
//          | frame_end, last                                   |
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data          | register write, always ready
//
//  one transaction per cycle sustained while rsp_ready holds; a transaction passes
//  through the request register and then the result register
//  the sequencer step (phase update and byte mux) is the only logic between them
//  rsp stalls back up through the request register only when both hold an entry
//  reset clears the handshake, the busy flag and the phase; config returns to
//  scan_horizontal 0 and column_offset 35

module display_rect_fill_sequencer #(
    parameter int PANEL_WIDTH  = drfs_pkg::DEFAULT_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = drfs_pkg::DEFAULT_PANEL_HEIGHT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                req_valid,
    output logic                                     req_ready,
    input  wire logic                                op,
    input  wire logic [drfs_pkg::COORD_W-1:0]        x_origin,
    input  wire logic [drfs_pkg::COORD_W-1:0]        y_origin,
    input  wire logic [drfs_pkg::COORD_W-1:0]        rect_width,
    input  wire logic [drfs_pkg::COORD_W-1:0]        rect_height,
    input  wire logic [drfs_pkg::COLOR_W-1:0]        fill_value,

    output logic                                     rsp_valid,
    input  wire logic                                rsp_ready,
    output logic [drfs_pkg::BYTE_W-1:0]              out_byte,
    output logic                                     is_data,
    output logic                                     frame_end,
    output logic                                     last,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [drfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [drfs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = drfs_pkg::COORD_W;
    localparam int BW = drfs_pkg::BOUND_W;
    localparam int PX = drfs_pkg::PIXELS_W;
    localparam int YW = drfs_pkg::BYTE_W;
    localparam int KW = drfs_pkg::COLOR_W;

    // sequencer phases: window bytes, then the pixel stream
    localparam logic [3:0] PH_COL_CMD   = 4'd0;
    localparam logic [3:0] PH_COL_FH    = 4'd1;
    localparam logic [3:0] PH_COL_FL    = 4'd2;
    localparam logic [3:0] PH_COL_LH    = 4'd3;
    localparam logic [3:0] PH_COL_LL    = 4'd4;
    localparam logic [3:0] PH_ROW_CMD   = 4'd5;
    localparam logic [3:0] PH_ROW_FH    = 4'd6;
    localparam logic [3:0] PH_ROW_FL    = 4'd7;
    localparam logic [3:0] PH_ROW_LH    = 4'd8;
    localparam logic [3:0] PH_ROW_LL    = 4'd9;
    localparam logic [3:0] PH_MEM_CMD   = 4'd10;
    localparam logic [3:0] PH_PIXELS    = 4'd11;

    // configuration registers
    logic                                scan_horizontal_reg;
    logic [drfs_pkg::CFG_DATA_W-1:0]     column_offset_reg;

    // request register
    logic          req_valid_reg;
    logic          op_reg;
    logic [CW-1:0] x_reg;
    logic [CW-1:0] y_reg;
    logic [CW-1:0] w_reg;
    logic [CW-1:0] h_reg;
    logic [KW-1:0] color_reg;

    // sequencer state
    logic          busy_reg,       busy_next;
    logic [3:0]    phase_reg,      phase_next;
    logic [BW-1:0] col_first_reg,  col_first_next;
    logic [BW-1:0] col_final_reg,  col_final_next;
    logic [BW-1:0] row_first_reg,  row_first_next;
    logic [BW-1:0] row_final_reg,  row_final_next;
    logic [PX-1:0] pixels_reg,     pixels_next;
    logic          low_half_reg,   low_half_next;
    logic [KW-1:0] held_color_reg, held_color_next;

    // result register
    logic          rsp_valid_reg,  rsp_valid_next;
    logic [YW-1:0] byte_reg,       byte_next;
    logic          is_data_reg,    is_data_next;
    logic          frame_end_reg,  frame_end_next;
    logic          last_reg,       last_next;

    logic              advance;
    logic              emit;
    logic              pixel_end;
    drfs_pkg::window_t win;

    // the request register moves on whenever the result slot is free or draining
    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign rsp_valid = rsp_valid_reg;
    assign out_byte  = byte_reg;
    assign is_data   = is_data_reg;
    assign frame_end = frame_end_reg;
    assign last      = last_reg;

    drfs_window_calc #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_window_calc (
        .scan_horizontal (scan_horizontal_reg),
        .column_offset   (column_offset_reg),
        .x_origin        (x_reg),
        .y_origin        (y_reg),
        .rect_width      (w_reg),
        .rect_height     (h_reg),
        .win             (win)
    );

    assign pixel_end = (pixels_reg <= PX'(1));

    always_comb
    begin
        busy_next       = busy_reg;
        phase_next      = phase_reg;
        col_first_next  = col_first_reg;
        col_final_next  = col_final_reg;
        row_first_next  = row_first_reg;
        row_final_next  = row_final_reg;
        pixels_next     = pixels_reg;
        low_half_next   = low_half_reg;
        held_color_next = held_color_reg;

        emit           = 1'b0;
        byte_next      = byte_reg;
        is_data_next   = is_data_reg;
        frame_end_next = frame_end_reg;
        last_next      = last_reg;

        if (advance)
        begin
            if (op_reg == drfs_pkg::OP_START)
            begin
                // starts while busy or off the panel are dropped
                if (!busy_reg && win.on_panel)
                begin
                    busy_next       = 1'b1;
                    phase_next      = PH_COL_CMD;
                    col_first_next  = win.col_first;
                    col_final_next  = win.col_final;
                    row_first_next  = win.row_first;
                    row_final_next  = win.row_final;
                    pixels_next     = win.pixels;
                    low_half_next   = 1'b0;
                    held_color_next = color_reg;
                end
            end
            else if (busy_reg)
            begin
                emit           = 1'b1;
                is_data_next   = 1'b1;
                frame_end_next = 1'b1;
                last_next      = 1'b0;
                phase_next     = phase_reg + 4'd1;
                case (phase_reg)
                    PH_COL_CMD:
                    begin
                        byte_next    = drfs_pkg::CMD_COLUMN_WINDOW;
                        is_data_next = 1'b0;
                    end
                    PH_COL_FH: byte_next = col_first_reg[BW-1:YW];
                    PH_COL_FL: byte_next = col_first_reg[YW-1:0];
                    PH_COL_LH: byte_next = col_final_reg[BW-1:YW];
                    PH_COL_LL: byte_next = col_final_reg[YW-1:0];
                    PH_ROW_CMD:
                    begin
                        byte_next    = drfs_pkg::CMD_ROW_WINDOW;
                        is_data_next = 1'b0;
                    end
                    PH_ROW_FH: byte_next = row_first_reg[BW-1:YW];
                    PH_ROW_FL: byte_next = row_first_reg[YW-1:0];
                    PH_ROW_LH: byte_next = row_final_reg[BW-1:YW];
                    PH_ROW_LL: byte_next = row_final_reg[YW-1:0];
                    PH_MEM_CMD:
                    begin
                        byte_next     = drfs_pkg::CMD_MEMORY_WRITE;
                        is_data_next  = 1'b0;
                        low_half_next = 1'b0;
                        // an empty rectangle ends on the memory-write command
                        if (pixels_reg == '0)
                        begin
                            last_next  = 1'b1;
                            busy_next  = 1'b0;
                            phase_next = PH_COL_CMD;
                        end
                        else
                        begin
                            phase_next = PH_PIXELS;
                        end
                    end
                    default:
                    begin
                        // pixel stream: high byte then low byte, one open frame
                        phase_next = phase_reg;
                        if (!low_half_reg)
                        begin
                            byte_next      = held_color_reg[KW-1:YW];
                            frame_end_next = 1'b0;
                            low_half_next  = 1'b1;
                        end
                        else
                        begin
                            byte_next      = held_color_reg[YW-1:0];
                            frame_end_next = pixel_end;
                            last_next      = pixel_end;
                            low_half_next  = 1'b0;
                            pixels_next    = pixels_reg - PX'(1);
                            if (pixel_end)
                            begin
                                pixels_next = '0;
                                busy_next   = 1'b0;
                                phase_next  = PH_COL_CMD;
                            end
                        end
                    end
                endcase
            end
        end

        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (emit)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg       <= 1'b0;
            rsp_valid_reg       <= 1'b0;
            busy_reg            <= 1'b0;
            phase_reg           <= PH_COL_CMD;
            low_half_reg        <= 1'b0;
            pixels_reg          <= '0;
            scan_horizontal_reg <= 1'b0;
            column_offset_reg   <= drfs_pkg::COLUMN_OFFSET_RESET;
        end
        else
        begin
            if (req_ready)
            begin
                req_valid_reg <= req_valid;
            end
            rsp_valid_reg <= rsp_valid_next;
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            low_half_reg  <= low_half_next;
            pixels_reg    <= pixels_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    drfs_pkg::CFG_SCAN_HORIZONTAL: scan_horizontal_reg <= cfg_data[0];
                    drfs_pkg::CFG_COLUMN_OFFSET:   column_offset_reg   <= cfg_data;
                    default:                       ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            op_reg    <= op;
            x_reg     <= x_origin;
            y_reg     <= y_origin;
            w_reg     <= rect_width;
            h_reg     <= rect_height;
            color_reg <= fill_value;
        end
        col_first_reg  <= col_first_next;
        col_final_reg  <= col_final_next;
        row_first_reg  <= row_first_next;
        row_final_reg  <= row_final_next;
        held_color_reg <= held_color_next;
        byte_reg       <= byte_next;
        is_data_reg    <= is_data_next;
        frame_end_reg  <= frame_end_next;
        last_reg       <= last_next;
    end

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the display rectangle fill sequencer: byte predictor and stimulus

// one byte as the panel link sees it
typedef struct packed {
    logic [drfs_pkg::BYTE_W-1:0] value;
    logic                        is_data;
    logic                        frame_end;
    logic                        last;
} panel_byte_t;

// byte positions inside a fill: column command, four column bytes, row command,
// four row bytes, memory-write command, then the pixel stream
localparam logic [3:0] PHASE_COL_CMD = 4'd0;
localparam logic [3:0] PHASE_ROW_CMD = 4'd5;
localparam logic [3:0] PHASE_MEM_CMD = 4'd10;
localparam logic [3:0] PHASE_PIXELS  = 4'd11;

// register indexes with nothing behind them
localparam logic [drfs_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
localparam logic [drfs_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

class fill_scoreboard;
    // register copies
    logic                          scan_horizontal;
    logic [drfs_pkg::CFG_DATA_W-1:0] column_offset;
    // fill in progress
    logic                          busy;
    logic [3:0]                    phase;
    logic [drfs_pkg::BOUND_W-1:0]  col_first;
    logic [drfs_pkg::BOUND_W-1:0]  col_final;
    logic [drfs_pkg::BOUND_W-1:0]  row_first;
    logic [drfs_pkg::BOUND_W-1:0]  row_final;
    logic [drfs_pkg::PIXELS_W-1:0] pixels_left;
    logic                          low_half_next;
    logic [drfs_pkg::COLOR_W-1:0]  held_color;

    panel_byte_t expected_bytes[$];
    int errors;
    int bytes_checked;
    int fills_started;
    int starts_rejected;
    int items_ignored;
    int items_effective;

    function new();
        scan_horizontal = 1'b0;
        column_offset   = drfs_pkg::COLUMN_OFFSET_RESET;
        busy            = 1'b0;
        phase           = PHASE_COL_CMD;
        col_first       = '0;
        col_final       = '0;
        row_first       = '0;
        row_final       = '0;
        pixels_left     = '0;
        low_half_next   = 1'b0;
        held_color      = '0;
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction

    function bit fill_active();
        return busy;
    endfunction

    function void write_register(logic [drfs_pkg::CFG_IDX_W-1:0] index,
                                 logic [drfs_pkg::CFG_DATA_W-1:0] data);
        case (index)
            drfs_pkg::CFG_SCAN_HORIZONTAL: scan_horizontal = data[0];
            drfs_pkg::CFG_COLUMN_OFFSET:   column_offset = data;
            default: ;
        endcase
    endfunction

    // 0..3 column window bytes, 4..7 row window bytes, high byte first
    function logic [drfs_pkg::BYTE_W-1:0] window_byte(int unsigned idx);
        logic [drfs_pkg::BOUND_W-1:0] bound;
        case (idx / 2)
            0:       bound = col_first;
            1:       bound = col_final;
            2:       bound = row_first;
            default: bound = row_final;
        endcase
        return (idx % 2) ? bound[7:0] : bound[15:8];
    endfunction

    function void queue_byte(logic [drfs_pkg::BYTE_W-1:0] value, logic data, logic fend,
                             logic fin);
        expected_bytes.push_back({value, data, fend, fin});
    endfunction

    function void note_request(logic op_code, logic [drfs_pkg::COORD_W-1:0] x,
                               logic [drfs_pkg::COORD_W-1:0] y,
                               logic [drfs_pkg::COORD_W-1:0] w,
                               logic [drfs_pkg::COORD_W-1:0] h,
                               logic [drfs_pkg::COLOR_W-1:0] color);
        int unsigned col;
        int unsigned row;
        int unsigned cols;
        int unsigned rows;
        int unsigned panel_cols;
        int unsigned panel_rows;
        logic        finishing;
        col = x;
        row = y;
        cols = w;
        rows = h;
        panel_cols = scan_horizontal ? drfs_pkg::DEFAULT_PANEL_HEIGHT
                                     : drfs_pkg::DEFAULT_PANEL_WIDTH;
        panel_rows = scan_horizontal ? drfs_pkg::DEFAULT_PANEL_WIDTH
                                     : drfs_pkg::DEFAULT_PANEL_HEIGHT;
        if (op_code == drfs_pkg::OP_START)
        begin
            if (busy || col >= panel_cols || row >= panel_rows)
            begin
                if (!busy)
                    starts_rejected++;
                items_ignored++;
                return;
            end
            if (cols > 0 && col + cols - 1 >= panel_cols)
                cols = panel_cols - col;
            if (rows > 0 && row + rows - 1 >= panel_rows)
                rows = panel_rows - row;
            // final bounds fall to the first bound - 1 for an empty side
            col_first     = 16'(col + column_offset);
            col_final     = 16'(col + cols + 32'hFFFF + column_offset);
            row_first     = 16'(row);
            row_final     = 16'(row + rows + 32'hFFFF);
            pixels_left   = 18'(cols * rows);
            held_color    = color;
            low_half_next = 1'b0;
            phase         = PHASE_COL_CMD;
            busy          = 1'b1;
            fills_started++;
            items_effective++;
            return;
        end
        if (!busy)
        begin
            items_ignored++;
            return;
        end
        items_effective++;
        if (phase == PHASE_COL_CMD)
        begin
            queue_byte(drfs_pkg::CMD_COLUMN_WINDOW, 1'b0, 1'b1, 1'b0);
            phase = phase + 4'd1;
        end
        else if (phase < PHASE_ROW_CMD)
        begin
            queue_byte(window_byte(phase - 1), 1'b1, 1'b1, 1'b0);
            phase = phase + 4'd1;
        end
        else if (phase == PHASE_ROW_CMD)
        begin
            queue_byte(drfs_pkg::CMD_ROW_WINDOW, 1'b0, 1'b1, 1'b0);
            phase = phase + 4'd1;
        end
        else if (phase < PHASE_MEM_CMD)
        begin
            queue_byte(window_byte(phase - 2), 1'b1, 1'b1, 1'b0);
            phase = phase + 4'd1;
        end
        else if (phase == PHASE_MEM_CMD)
        begin
            if (pixels_left == 0)
            begin
                queue_byte(drfs_pkg::CMD_MEMORY_WRITE, 1'b0, 1'b1, 1'b1);
                busy  = 1'b0;
                phase = PHASE_COL_CMD;
            end
            else
            begin
                queue_byte(drfs_pkg::CMD_MEMORY_WRITE, 1'b0, 1'b1, 1'b0);
                phase         = PHASE_PIXELS;
                low_half_next = 1'b0;
            end
        end
        else if (!low_half_next)
        begin
            queue_byte(held_color[15:8], 1'b1, 1'b0, 1'b0);
            low_half_next = 1'b1;
        end
        else
        begin
            finishing = (pixels_left <= 1);
            queue_byte(held_color[7:0], 1'b1, finishing, finishing);
            low_half_next = 1'b0;
            pixels_left   = pixels_left - 1'b1;
            if (finishing)
            begin
                pixels_left = '0;
                busy        = 1'b0;
                phase       = PHASE_COL_CMD;
            end
        end
    endfunction

    function void check_byte(panel_byte_t actual);
        panel_byte_t want;
        if (expected_bytes.size() == 0)
        begin
            errors++;
            $display("%0t: byte %02h arrived with nothing expected", $time, actual.value);
            return;
        end
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (want.value != actual.value)
        begin
            errors++;
            $display("%0t: out_byte expected %02h actual %02h", $time, want.value, actual.value);
        end
        if (want.is_data != actual.is_data)
        begin
            errors++;
            $display("%0t: is_data expected %0b actual %0b", $time, want.is_data, actual.is_data);
        end
        if (want.frame_end != actual.frame_end)
        begin
            errors++;
            $display("%0t: frame_end expected %0b actual %0b", $time,
                     want.frame_end, actual.frame_end);
        end
        if (want.last != actual.last)
        begin
            errors++;
            $display("%0t: last expected %0b actual %0b", $time, want.last, actual.last);
        end
    endfunction
endclass

module tb_top;

    // gap draw ceiling, pipeline settle time after the last byte, watchdog
    localparam int MAX_GAP           = 13;
    localparam int SETTLE_CYCLES     = 6;
    localparam int CYCLE_LIMIT       = 300_000;
    localparam int NUM_SETTINGS      = 7;
    localparam int ITEMS_PER_SETTING = 100;

    localparam int CW = drfs_pkg::COORD_W;
    localparam int KW = drfs_pkg::COLOR_W;
    localparam int IW = drfs_pkg::CFG_IDX_W;
    localparam int DW = drfs_pkg::CFG_DATA_W;

    logic clk = 1'b0;
    logic rst_n;

    logic                        req_valid;
    logic                        req_ready;
    logic                        op;
    logic [CW-1:0]               x_origin;
    logic [CW-1:0]               y_origin;
    logic [CW-1:0]               rect_width;
    logic [CW-1:0]               rect_height;
    logic [KW-1:0]               fill_value;

    logic                        rsp_valid;
    logic                        rsp_ready;
    logic [drfs_pkg::BYTE_W-1:0] out_byte;
    logic                        is_data;
    logic                        frame_end;
    logic                        last;

    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [IW-1:0]               cfg_index;
    logic [DW-1:0]               cfg_data;

    fill_scoreboard sb;

    // both sides draw their per-transaction wait from 0..max_gap
    int max_gap;
    // one-shot long hold-off for the byte receiver
    int rsp_hold_cycles;
    int register_writes;
    int cycle_count;

    display_rect_fill_sequencer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .op          (op),
        .x_origin    (x_origin),
        .y_origin    (y_origin),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .fill_value  (fill_value),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .out_byte    (out_byte),
        .is_data     (is_data),
        .frame_end   (frame_end),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sample every handshake at the rising edge; results are checked before the
    // request of the same edge is noted, so a fresh request never masks a stray byte
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                sb.check_byte({out_byte, is_data, frame_end, last});
            if (cfg_valid && cfg_ready)
                sb.write_register(cfg_index, cfg_data);
            if (req_valid && req_ready)
                sb.note_request(op, x_origin, y_origin, rect_width, rect_height, fill_value);
        end
    end

    // byte receiver: random wait before each transaction, or a long hold when asked
    initial
    begin
        int wait_cycles;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (rsp_hold_cycles > 0)
            begin
                wait_cycles = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end
            else
                wait_cycles = $urandom_range(0, max_gap);
            if (wait_cycles > 0)
            begin
                rsp_ready = 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            rsp_ready = 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            @(negedge clk);
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d bytes still expected", cycle_count,
                 sb.pending());
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int unsigned panel_cols();
        return sb.scan_horizontal ? drfs_pkg::DEFAULT_PANEL_HEIGHT
                                  : drfs_pkg::DEFAULT_PANEL_WIDTH;
    endfunction

    function automatic int unsigned panel_rows();
        return sb.scan_horizontal ? drfs_pkg::DEFAULT_PANEL_WIDTH
                                  : drfs_pkg::DEFAULT_PANEL_HEIGHT;
    endfunction

    // entered and left at a falling edge; valid only drops when a gap is drawn
    task automatic send_item(logic op_code, logic [CW-1:0] x, logic [CW-1:0] y,
                             logic [CW-1:0] w, logic [CW-1:0] h,
                             logic [KW-1:0] color);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op          = op_code;
        x_origin    = x;
        y_origin    = y;
        rect_width  = w;
        rect_height = h;
        fill_value  = color;
        req_valid   = 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    // tick payload is don't-care, so it carries noise
    task automatic send_tick();
        send_item(drfs_pkg::OP_TICK, 9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom),
                  16'($urandom));
    endtask

    // sender stops until every expected byte is back and the pipeline has settled
    task automatic drain();
        req_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_register(logic [IW-1:0] index, logic [DW-1:0] data);
        drain();
        cfg_index = index;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        register_writes++;
    endtask

    // tick until the fill completes, with stray starts and sender pauses mixed in
    task automatic finish_fill();
        int pick;
        while (sb.fill_active())
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                send_item(drfs_pkg::OP_START, 9'($urandom), 9'($urandom), 9'($urandom),
                          9'($urandom), 16'($urandom));
            else if (pick < 4)
                drain();
            else
                send_tick();
        end
    endtask

    task automatic run_fill(logic [CW-1:0] x, logic [CW-1:0] y,
                            logic [CW-1:0] w, logic [CW-1:0] h,
                            logic [KW-1:0] color);
        send_item(drfs_pkg::OP_START, x, y, w, h, color);
        finish_fill();
    endtask

    // mostly small rectangles anywhere; some hug the far edge with a huge
    // requested size so clipping cuts them down to a few pixels
    task automatic random_fill();
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] w;
        logic [CW-1:0] h;
        if ($urandom_range(0, 9) < 7)
        begin
            x = 9'($urandom_range(0, panel_cols() - 1));
            w = 9'($urandom_range(0, 5));
        end
        else
        begin
            x = 9'(panel_cols() - 1 - $urandom_range(0, 5));
            w = 9'($urandom_range(0, 511));
        end
        if ($urandom_range(0, 9) < 7)
        begin
            y = 9'($urandom_range(0, panel_rows() - 1));
            h = 9'($urandom_range(0, 5));
        end
        else
        begin
            y = 9'(panel_rows() - 1 - $urandom_range(0, 5));
            h = 9'($urandom_range(0, 511));
        end
        run_fill(x, y, w, h, 16'($urandom));
    endtask

    initial
    begin
        int phase_goal;
        int pick;
        logic          scan_plan [NUM_SETTINGS];
        logic [DW-1:0] offset_plan [NUM_SETTINGS];

        sb = new();
        max_gap         = MAX_GAP;
        rsp_hold_cycles = 0;
        register_writes = 0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        op          = drfs_pkg::OP_TICK;
        x_origin    = '0;
        y_origin    = '0;
        rect_width  = '0;
        rect_height = '0;
        fill_value  = '0;
        cfg_valid   = 1'b0;
        cfg_index   = drfs_pkg::CFG_SCAN_HORIZONTAL;
        cfg_data    = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part, reset registers: vertical scan, offset 35
        send_tick();                                         // tick with no fill running
        // first column off panel, first row off panel, everything at its top
        send_item(drfs_pkg::OP_START, 9'd240, 9'd0, 9'd1, 9'd1, 16'h5555);
        send_item(drfs_pkg::OP_START, 9'd0, 9'd320, 9'd1, 9'd1, 16'hAAAA);
        send_item(drfs_pkg::OP_START, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 16'hFFFF);
        run_fill(9'd0, 9'd0, 9'd0, 9'd0, 16'hFFFF);          // empty, row bound wraps below zero
        run_fill(9'd239, 9'd319, 9'h1FF, 9'h1FF, 16'h0000);  // corner, clipped to one pixel
        run_fill(9'd0, 9'd100, 9'd0, 9'h1FF, 16'h8001);      // zero width, height clipped

        // receiver holds off long while the sender keeps ticking at full rate
        max_gap = 0;
        rsp_hold_cycles = 150;
        run_fill(9'd10, 9'd20, 9'd6, 9'd6, 16'($urandom));
        max_gap = MAX_GAP;

        // registers rewritten mid-fill must not disturb the window already latched
        send_item(drfs_pkg::OP_START, 9'd5, 9'd7, 9'd3, 9'd2, 16'hA5C3);
        repeat (4) send_tick();
        program_register(drfs_pkg::CFG_SCAN_HORIZONTAL, 8'd1);
        program_register(drfs_pkg::CFG_COLUMN_OFFSET, 8'd255);
        finish_fill();

        // horizontal scan, offset 255: column bounds carry into the high byte
        run_fill(9'd319, 9'd239, 9'h1FF, 9'd0, 16'h1234);
        send_item(drfs_pkg::OP_START, 9'd320, 9'd0, 9'd1, 9'd1, 16'h0F0F);
        send_item(drfs_pkg::OP_START, 9'd0, 9'd240, 9'd1, 9'd1, 16'hF0F0);
        run_fill(9'd300, 9'd235, 9'h1FF, 9'h1FF, 16'h7E81); // clipped to 20 by 5
        program_register(CFG_UNMAPPED_LO, 8'hFF);
        program_register(CFG_UNMAPPED_HI, 8'hFF);

        // random part, one register setting per stretch, extremes first
        scan_plan   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
        offset_plan = '{8'd0, 8'd255, 8'd255, 8'd0, 8'($urandom), 8'($urandom),
                        drfs_pkg::COLUMN_OFFSET_RESET};
        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            program_register(drfs_pkg::CFG_SCAN_HORIZONTAL, {7'd0, scan_plan[s]});
            program_register(drfs_pkg::CFG_COLUMN_OFFSET, offset_plan[s]);
            if (s % 3 == 1)
                program_register((s % 2) ? CFG_UNMAPPED_HI : CFG_UNMAPPED_LO, 8'($urandom));
            // some stretches run back to back with no idling on either side
            max_gap = (s == 2 || s == 5) ? 0 : MAX_GAP;
            phase_goal = sb.items_effective + ITEMS_PER_SETTING;
            while (sb.items_effective < phase_goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    send_tick();
                else if (pick < 11)
                    send_item(drfs_pkg::OP_START, 9'($urandom_range(panel_cols(), 511)),
                              9'($urandom), 9'($urandom), 9'($urandom), 16'($urandom));
                else if (pick < 14)
                    send_item(drfs_pkg::OP_START, 9'($urandom),
                              9'($urandom_range(panel_rows(), 511)), 9'($urandom),
                              9'($urandom), 16'($urandom));
                else
                    random_fill();
            end
        end

        // one clipped corner fill at full rate
        program_register(drfs_pkg::CFG_SCAN_HORIZONTAL, 8'd1);
        program_register(drfs_pkg::CFG_COLUMN_OFFSET, 8'($urandom));
        max_gap = 0;
        run_fill(9'd310, 9'd230, 9'h1FF, 9'h1FF, 16'($urandom));

        drain();
        $display("covered %0d fills, %0d off-panel starts, %0d ignored requests",
                 sb.fills_started, sb.starts_rejected, sb.items_ignored);
        $display("checked %0d panel bytes from %0d effective requests, %0d register writes",
                 sb.bytes_checked, sb.items_effective, register_writes);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/drfs_pkg.sv
rtl/drfs_window_calc.sv
rtl/display_rect_fill_sequencer.sv
test/tb_top.sv
